>>> rtl/core/ubcf_pkg.sv
// Shared constants, register indexes and a pixel-mask helper for the uniform border crop finder.
`timescale 1ns / 1ps

package ubcf_pkg;

  localparam int unsigned DimW   = 16;
  localparam int unsigned PixW   = 24;
  localparam int unsigned BitsW  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_BITS   = 2'd2;

  localparam logic [DimW-1:0]  FRAME_WIDTH_RST  = 16'd1;
  localparam logic [DimW-1:0]  FRAME_HEIGHT_RST = 16'd1;
  localparam logic [BitsW-1:0] PIXEL_BITS_RST   = 5'd24;

  // All ones in the compared bits, capped at the full pixel width.
  function automatic logic [PixW-1:0] pixel_mask(input logic [BitsW-1:0] bits);
    logic [PixW-1:0] m;
    if (bits >= 5'd24) begin
      m = '1;
    end else begin
      m = ~({PixW{1'b1}} << bits);
    end
    return m;
  endfunction

endpackage

>>> rtl/core/uniform_border_crop_finder.sv
// Top level: streaming uniform border detector with result pipeline.
// Throughput: one pixel transaction per cycle while in_stall is low, with no frame store.
// After the last pixel of a frame is accepted, its result passes the snapshot
//   register, then the result register, which raises out_valid.
// in_stall is high only while both stages are full and out_stall holds the result.
// Reset (rst_n low, synchronous): 1 x 1 frame, 24-bit pixels, scan and pipeline cleared.
`timescale 1ns / 1ps

module uniform_border_crop_finder
  import ubcf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DimW-1:0]     cfg_data,
  // pixel input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PixW-1:0]     in_pixel,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DimW-1:0]     out_left_border,
  output logic [DimW-1:0]     out_right_border,
  output logic [DimW-1:0]     out_top_border,
  output logic [DimW-1:0]     out_bottom_border,
  output logic [DimW-1:0]     out_new_width,
  output logic [DimW-1:0]     out_new_height,
  output logic                out_crop_valid
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DimW-1:0]  frame_width_r;
  logic [DimW-1:0]  frame_height_r;
  logic [BitsW-1:0] pixel_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      pixel_bits_r   <= PIXEL_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        CFG_PIXEL_BITS:   pixel_bits_r   <= cfg_data[BitsW-1:0];
        default:          ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  // The snapshot stage moves on whenever the result register is free or
  // its result is being taken this cycle.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Running scan state
  // ---------------------------------------------------------------------
  logic [DimW-1:0]        col_r, row_r;
  logic [PixW-1:0]        tl_ref_r, tr_ref_r;
  logic [DimW-1:0]        run_start_r;
  logic [DimW-1:0]        min_left_r;
  logic signed [DimW:0]   max_right_r;     // -1 while no mismatch seen
  logic [DimW-1:0]        top_rows_r;
  logic                   top_done_r;
  logic                   row_uni_r;
  logic [PixW-1:0]        row_first_r;
  logic [DimW-1:0]        trail_rows_r;
  logic [PixW-1:0]        trail_val_r;

  logic [PixW-1:0]        pix;
  logic                   x_zero, y_zero;
  logic [PixW-1:0]        tl_ref_nxt, tr_ref_nxt, row_first_nxt, trail_val_nxt;
  logic [DimW-1:0]        run_start_nxt, min_left_nxt, top_rows_nxt, trail_rows_nxt;
  logic signed [DimW:0]   max_right_pix, max_right_nxt, run_last;
  logic                   top_done_nxt, row_uni_nxt;
  logic [DimW:0]          col_inc, row_inc;
  logic                   row_end, frame_end;

  always_comb begin
    pix    = in_pixel & pixel_mask(pixel_bits_r);
    x_zero = (col_r == '0);
    y_zero = (row_r == '0);

    // first pixel of the frame sets the top-left reference
    tl_ref_nxt = (x_zero && y_zero) ? pix : tl_ref_r;

    // right border: row 0 tracks the closing run, later rows the last mismatch
    run_start_nxt = run_start_r;
    tr_ref_nxt    = tr_ref_r;
    max_right_pix = max_right_r;
    if (y_zero) begin
      if (x_zero || pix != tr_ref_r) begin
        run_start_nxt = col_r;
      end
      tr_ref_nxt = pix;
    end else if (pix != tr_ref_r && $signed({1'b0, col_r}) > max_right_r) begin
      max_right_pix = $signed({1'b0, col_r});
    end

    // left border: earliest column that differs from top-left
    min_left_nxt = min_left_r;
    if (pix != tl_ref_nxt && col_r < min_left_r) begin
      min_left_nxt = col_r;
    end

    // whole-row uniformity
    if (x_zero) begin
      row_first_nxt = pix;
      row_uni_nxt   = 1'b1;
    end else begin
      row_first_nxt = row_first_r;
      row_uni_nxt   = row_uni_r && (pix == row_first_r);
    end

    col_inc   = {1'b0, col_r} + 17'd1;
    row_inc   = {1'b0, row_r} + 17'd1;
    row_end   = !(col_inc < {1'b0, frame_width_r});
    frame_end = row_end && !(row_inc < {1'b0, frame_height_r});

    // row-end bookkeeping
    run_last       = $signed({1'b0, run_start_nxt}) - 17'sd1;
    max_right_nxt  = max_right_pix;
    top_rows_nxt   = top_rows_r;
    top_done_nxt   = top_done_r;
    trail_rows_nxt = trail_rows_r;
    trail_val_nxt  = trail_val_r;
    if (row_end) begin
      if (y_zero && run_last > max_right_pix) begin
        max_right_nxt = run_last;
      end
      if (!top_done_r) begin
        if (row_uni_nxt && row_first_nxt == tl_ref_nxt) begin
          top_rows_nxt = top_rows_r + 16'd1;
        end else begin
          top_done_nxt = 1'b1;
        end
      end
      if (row_uni_nxt) begin
        if (trail_rows_r != '0 && trail_val_r == row_first_nxt) begin
          trail_rows_nxt = trail_rows_r + 16'd1;
        end else begin
          trail_rows_nxt = 16'd1;
          trail_val_nxt  = row_first_nxt;
        end
      end else begin
        trail_rows_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && frame_end)) begin
      // start a fresh frame
      col_r        <= '0;
      row_r        <= '0;
      tl_ref_r     <= '0;
      tr_ref_r     <= '0;
      run_start_r  <= '0;
      min_left_r   <= '1;
      max_right_r  <= -17'sd1;
      top_rows_r   <= '0;
      top_done_r   <= 1'b0;
      row_uni_r    <= 1'b1;
      row_first_r  <= '0;
      trail_rows_r <= '0;
      trail_val_r  <= '0;
    end else if (in_acc) begin
      col_r        <= row_end ? '0 : col_inc[DimW-1:0];
      row_r        <= row_end ? row_inc[DimW-1:0] : row_r;
      tl_ref_r     <= tl_ref_nxt;
      tr_ref_r     <= tr_ref_nxt;
      run_start_r  <= run_start_nxt;
      min_left_r   <= min_left_nxt;
      max_right_r  <= max_right_nxt;
      top_rows_r   <= top_rows_nxt;
      top_done_r   <= top_done_nxt;
      row_uni_r    <= row_uni_nxt;
      row_first_r  <= row_first_nxt;
      trail_rows_r <= trail_rows_nxt;
      trail_val_r  <= trail_val_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: end-of-frame snapshot of the raw border measurements
  // ---------------------------------------------------------------------
  logic [DimW-1:0]      s1_left_r, s1_top_r, s1_bottom_r, s1_w_r, s1_h_r;
  logic signed [DimW:0] s1_max_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc && frame_end) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && frame_end) begin
      s1_left_r      <= min_left_nxt;
      s1_max_right_r <= max_right_nxt;
      s1_top_r       <= top_rows_nxt;
      // bottom rows count only if the final row itself is uniform
      s1_bottom_r    <= row_uni_nxt ? trail_rows_nxt : '0;
      s1_w_r         <= frame_width_r;
      s1_h_r         <= frame_height_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: clamp, size check and new dimensions
  // ---------------------------------------------------------------------
  logic signed [DimW+1:0] right_full;
  logic [DimW-1:0]        left_c, right_c, top_c, bot_c, new_w, new_h;
  logic [DimW:0]          lr_sum, tb_sum;
  logic                   crop_ok;

  always_comb begin
    right_full = $signed({2'b00, s1_w_r}) - 18'sd1
               - $signed({s1_max_right_r[DimW], s1_max_right_r});
    if (right_full < 18'sd0) begin
      right_c = '0;
    end else if (right_full > $signed({2'b00, s1_w_r})) begin
      right_c = s1_w_r;
    end else begin
      right_c = right_full[DimW-1:0];
    end
    left_c = (s1_left_r > s1_w_r) ? s1_w_r : s1_left_r;
    top_c  = (s1_top_r > s1_h_r) ? s1_h_r : s1_top_r;
    bot_c  = (s1_bottom_r > s1_h_r) ? s1_h_r : s1_bottom_r;

    lr_sum  = {1'b0, left_c} + {1'b0, right_c};
    tb_sum  = {1'b0, top_c} + {1'b0, bot_c};
    // borders covering the whole frame, or no border at all, give no crop
    crop_ok = (lr_sum < {1'b0, s1_w_r}) && (tb_sum < {1'b0, s1_h_r})
           && (lr_sum != '0 || tb_sum != '0);
    new_w   = crop_ok ? (s1_w_r - lr_sum[DimW-1:0]) : s1_w_r;
    new_h   = crop_ok ? (s1_h_r - tb_sum[DimW-1:0]) : s1_h_r;
  end

  logic [DimW-1:0] left_r, right_r, top_r, bottom_r, new_w_r, new_h_r;
  logic            crop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      left_r   <= left_c;
      right_r  <= right_c;
      top_r    <= top_c;
      bottom_r <= bot_c;
      new_w_r  <= new_w;
      new_h_r  <= new_h;
      crop_r   <= crop_ok;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_border   = left_r;
  assign out_right_border  = right_r;
  assign out_top_border    = top_r;
  assign out_bottom_border = bottom_r;
  assign out_new_width     = new_w_r;
  assign out_new_height    = new_h_r;
  assign out_crop_valid    = crop_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a new result only follows a filled snapshot
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a snapshot");

  // a held result must not lose the waiting snapshot
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("snapshot dropped while result stalled");

  // last pixel restarts the scan at the origin
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (col_r == '0 && row_r == '0 && s1_valid_r))
    else $error("frame end did not restart the scan");

  // a crop never yields an empty frame
  a_crop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && crop_r) |-> (new_w_r != '0 && new_h_r != '0))
    else $error("crop flagged with an empty result");

endmodule
